/* rtl/core/assert_macros.svh */
// Assertion macros shared by the chord detect RTL.
// Self-contained; expects signals clk and arst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while in reset
`define KMDC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define KMDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define KMDC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define KMDC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/kmdc_pkg.sv */
// Package for the key matrix debounce and chord detect core.
// Types, constants and the per-column chord decode; no dependencies.
package kmdc_pkg;

	localparam int KEYS_PER_ROW = 4;
	localparam int ROOT_W       = 2;
	localparam int THR_W        = 4;
	localparam int CNT_W        = 4;

	localparam logic [THR_W-1:0] THRESHOLD_RESET = 4'd3;

	typedef logic [KEYS_PER_ROW-1:0] row_keys_t;

	// One scan or one stable image of the matrix
	typedef struct packed {
		row_keys_t major;
		row_keys_t minor;
		row_keys_t seventh;
	} key_rows_t;

	typedef enum logic [2:0] {
		NO_CHORD    = 3'd0,
		CHORD_MAJ   = 3'd1,
		CHORD_MIN   = 3'd2,
		CHORD_MAJ7  = 3'd3,
		CHORD_MIN7  = 3'd4,
		CHORD_DIM   = 3'd5,
		CHORD_AUG   = 3'd6
	} chord_type_t;

	// Chord formed by one column's stable row bits
	function automatic chord_type_t column_chord(logic maj, logic min, logic sev);
		chord_type_t t;
		if (maj && min && sev) begin
			t = CHORD_AUG;
		end else if (maj && min) begin
			t = CHORD_DIM;
		end else if (maj && sev) begin
			t = CHORD_MAJ7;
		end else if (min && sev) begin
			t = CHORD_MIN7;
		end else if (maj) begin
			t = CHORD_MAJ;
		end else if (min) begin
			t = CHORD_MIN;
		end else begin
			t = NO_CHORD;
		end
		return t;
	endfunction

endpackage

/* rtl/core/kmdc_if.sv */
// Valid/ready channel interfaces for scan items and chord result items.
// Depends on kmdc_pkg for field widths.
interface kmdc_scan_if;
	import kmdc_pkg::*;

	logic      valid;
	logic      ready;
	row_keys_t major_row_keys;
	row_keys_t minor_row_keys;
	row_keys_t seventh_row_keys;

	modport source (output valid, major_row_keys, minor_row_keys, seventh_row_keys,
		input ready);
	modport sink (input valid, major_row_keys, minor_row_keys, seventh_row_keys,
		output ready);
endinterface

interface kmdc_chord_if;
	import kmdc_pkg::*;

	logic              valid;
	logic              ready;
	logic [ROOT_W-1:0] chord_root;
	logic [2:0]        chord_type;

	modport source (output valid, chord_root, chord_type, input ready);
	modport sink (input valid, chord_root, chord_type, output ready);
endinterface

/* rtl/core/kmdc_debounce.sv */
// Per-key counter debounce for the 3-row key matrix.
// Depends on kmdc_pkg; holds the stable key image and one counter per key.
module kmdc_debounce (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [kmdc_pkg::THR_W-1:0] thr,
	input  kmdc_pkg::key_rows_t      raw,
	output kmdc_pkg::key_rows_t      stable_next
);
	import kmdc_pkg::*;

	localparam int NKEYS = 3 * KEYS_PER_ROW;

	logic [NKEYS-1:0] stable_q;
	logic [NKEYS-1:0] stable_d;
	logic [NKEYS-1:0] raw_flat;
	logic [CNT_W-1:0] cnt_q [NKEYS];
	logic [CNT_W-1:0] cnt_d [NKEYS];

	assign raw_flat = raw;

	// Counter update and flip decision, one lane per key
	always_comb begin
		for (int k = 0; k < NKEYS; k++) begin
			logic [CNT_W-1:0] inc;
			inc = cnt_q[k] + CNT_W'(1);
			stable_d[k] = stable_q[k];
			if (raw_flat[k] == stable_q[k]) begin
				cnt_d[k] = '0;
			end else if (inc >= thr) begin
				stable_d[k] = raw_flat[k];
				cnt_d[k] = '0;
			end else begin
				cnt_d[k] = inc;
			end
		end
	end

	assign stable_next = stable_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= '0;
			for (int k = 0; k < NKEYS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (en) begin
			stable_q <= stable_d;
			for (int k = 0; k < NKEYS; k++) begin
				cnt_q[k] <= cnt_d[k];
			end
		end
	end

endmodule

/* rtl/core/key_matrix_debounce_chord_detect_core.sv */
// Key matrix debounce and chord detect core: 3 rows by 4 columns.
// Input reg, then result reg; debounce update and priority decode share one stage.
// Throughput: 1 scan item per cycle, less while the chord output stalls.
// Reset (arst_n low): keys released, counters zero, threshold 3, root 0, type none.
// Depends on kmdc_pkg, kmdc_if, kmdc_debounce and assert_macros.svh.
module key_matrix_debounce_chord_detect_core (
	input  logic                       clk,
	input  logic                       arst_n,
	kmdc_scan_if.sink                  scan,
	kmdc_chord_if.source               chord,
	input  logic                       cfg_we,
	input  logic [kmdc_pkg::THR_W-1:0] cfg_wdata
);
	import kmdc_pkg::*;

	`include "assert_macros.svh"

	logic              valid_s1;
	key_rows_t         raw_s1;
	logic              out_valid_q;
	logic [ROOT_W-1:0] root_q;
	chord_type_t       type_q;
	logic [THR_W-1:0]  thr_q;
	logic              advance;
	logic              upd;
	key_rows_t         stable_next;
	logic              found;
	logic [ROOT_W-1:0] found_root;
	chord_type_t       found_type;

	// Handshake: result register drains or is empty, input stage follows
	assign advance     = !out_valid_q || chord.ready;
	assign scan.ready  = !valid_s1 || advance;
	assign upd         = valid_s1 && advance;

	// Threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.ready) begin
			valid_s1 <= scan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			raw_s1.major   <= scan.major_row_keys;
			raw_s1.minor   <= scan.minor_row_keys;
			raw_s1.seventh <= scan.seventh_row_keys;
		end
	end

	kmdc_debounce u_debounce (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (upd),
		.thr         (thr_q),
		.raw         (raw_s1),
		.stable_next (stable_next)
	);

	// Lowest column with a chord wins; walk down so column 0 is assigned last
	always_comb begin
		found      = 1'b0;
		found_root = '0;
		found_type = NO_CHORD;
		for (int c = KEYS_PER_ROW - 1; c >= 0; c--) begin
			chord_type_t t;
			t = column_chord(stable_next.major[c], stable_next.minor[c],
				stable_next.seventh[c]);
			if (t != NO_CHORD) begin
				found      = 1'b1;
				found_root = ROOT_W'(c);
				found_type = t;
			end
		end
	end

	// Result register; root is held when no column forms a chord
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			root_q      <= '0;
			type_q      <= NO_CHORD;
		end else if (upd) begin
			out_valid_q <= 1'b1;
			type_q      <= found_type;
			if (found) begin
				root_q <= found_root;
			end
		end else if (chord.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign chord.valid      = out_valid_q;
	assign chord.chord_root = root_q;
	assign chord.chord_type = type_q;

	// Checks
	`KMDC_ASSERT_NEXT(a_upd_gives_item, upd, out_valid_q, "processed scan produced no chord item")
	`KMDC_ASSERT_NEXT(a_root_held, upd && !found, $stable(root_q), "root changed with no chord")
	`KMDC_ASSERT_IMPLY(a_stall_cause, !scan.ready, valid_s1 && out_valid_q && !chord.ready,
		"scan stalled without a full pipeline")

endmodule

/* sim/testbench.sv */
// Testbench for key_matrix_debounce_chord_detect_core: debounce and chord decode.
// Depends on kmdc_pkg, kmdc_if and the core RTL; needs no other files.
`timescale 1ns / 1ps

module testbench;
	import kmdc_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int SQUEEZE_CYCLES = 300;

	// Expected chord item
	typedef struct packed {
		logic [ROOT_W-1:0] root;
		chord_type_t       kind;
	} chord_item_t;

	// Debounce and chord predictor plus queue of pending chord items
	class chord_scoreboard;
		logic [THR_W-1:0]  threshold;
		row_keys_t         stable_rows[3];
		logic [CNT_W-1:0]  mismatch[3][KEYS_PER_ROW];
		logic [ROOT_W-1:0] held_root;
		chord_type_t       held_kind;
		chord_item_t       expected_chords[$];
		int                errors;
		int                scans;
		int                seen[7];

		function new();
			threshold = THRESHOLD_RESET;
			for (int r = 0; r < 3; r++) begin
				stable_rows[r] = '0;
				for (int c = 0; c < KEYS_PER_ROW; c++) begin
					mismatch[r][c] = '0;
				end
			end
			held_root = '0;
			held_kind = NO_CHORD;
			errors = 0;
			scans = 0;
			for (int i = 0; i < 7; i++) begin
				seen[i] = 0;
			end
		endfunction

		// Advance the debounce state by one accepted scan and queue the chord item
		function void note_scan(key_rows_t scan_in);
			row_keys_t        raw[3];
			logic [CNT_W-1:0] next_cnt;
			logic [2:0]       code;
			chord_type_t      kind;
			bit               found;
			raw[0] = scan_in.major;
			raw[1] = scan_in.minor;
			raw[2] = scan_in.seventh;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < KEYS_PER_ROW; c++) begin
					if (raw[r][c] == stable_rows[r][c]) begin
						mismatch[r][c] = '0;
					end else begin
						next_cnt = mismatch[r][c] + 1'b1;
						// zero threshold flips at once, like a threshold of one
						if (next_cnt >= threshold) begin
							stable_rows[r][c] = raw[r][c];
							next_cnt = '0;
						end
						mismatch[r][c] = next_cnt;
					end
				end
			end
			// lowest column holding a chord wins
			found = 0;
			for (int c = 0; c < KEYS_PER_ROW; c++) begin
				if (!found) begin
					code = {stable_rows[0][c], stable_rows[1][c], stable_rows[2][c]};
					case (code)
						3'b111: kind = CHORD_AUG;
						3'b110: kind = CHORD_DIM;
						3'b101: kind = CHORD_MAJ7;
						3'b011: kind = CHORD_MIN7;
						3'b100: kind = CHORD_MAJ;
						3'b010: kind = CHORD_MIN;
						default: kind = NO_CHORD;
					endcase
					if (kind != NO_CHORD) begin
						held_root = c[ROOT_W-1:0];
						held_kind = kind;
						found = 1;
					end
				end
			end
			// no chord anywhere: type none, root kept
			if (!found) begin
				held_kind = NO_CHORD;
			end
			expected_chords.push_back('{held_root, held_kind});
			scans++;
		endfunction

		function void check_chord(logic [ROOT_W-1:0] root, logic [2:0] kind);
			chord_item_t want;
			if (expected_chords.size() == 0) begin
				$error("chord item with nothing expected: root %0d type %0d", root, kind);
				errors++;
			end else begin
				want = expected_chords.pop_front();
				if (root !== want.root) begin
					$error("chord_root: expected %0d, actual %0d", want.root, root);
					errors++;
				end
				if (kind !== want.kind) begin
					$error("chord_type: expected %0d, actual %0d", want.kind, kind);
					errors++;
				end
				if (kind < 7) begin
					seen[kind]++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [THR_W-1:0] cfg_wdata;

	kmdc_scan_if  scan ();
	kmdc_chord_if chord ();

	key_matrix_debounce_chord_detect_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.scan      (scan.sink),
		.chord     (chord.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	chord_scoreboard sb;
	bit hold_off_req;
	int burst_left;
	int settings_used;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Drive one scan item, with bursts and gaps on the sender side
	task automatic drive_scan(input key_rows_t k);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				scan.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		scan.valid            <= 1'b1;
		scan.major_row_keys   <= k.major;
		scan.minor_row_keys   <= k.minor;
		scan.seventh_row_keys <= k.seventh;
		do begin
			@(posedge clk);
		end while (!(scan.valid && scan.ready));
		sb.note_scan(k);
	endtask

	// Stop offering and wait until every chord item has come back
	task automatic drain();
		scan.valid <= 1'b0;
		while (sb.expected_chords.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = v;
		settings_used++;
	endtask

	// Random phase: mostly held patterns with bounce, some raw noise
	task automatic run_phase(input logic [THR_W-1:0] thr, input int n_scans, input bit squeeze);
		int        sent;
		int        hold;
		int        eff;
		int        col;
		int        pos;
		key_rows_t pat;
		key_rows_t s;
		write_threshold(thr);
		if (squeeze) begin
			hold_off_req = 1'b1;
		end
		eff = (thr == 0) ? 1 : thr;
		sent = 0;
		while (sent < n_scans) begin
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 3))
					0: pat = key_rows_t'($urandom);
					1: pat = key_rows_t'($urandom & $urandom);
					2: begin
						col = $urandom_range(0, KEYS_PER_ROW - 1);
						pat = '0;
						pat.major[col]   = 1'($urandom_range(0, 1));
						pat.minor[col]   = 1'($urandom_range(0, 1));
						pat.seventh[col] = 1'($urandom_range(0, 1));
					end
					default: pat = ($urandom_range(0, 1) == 0) ? '0 : key_rows_t'($urandom);
				endcase
				if ($urandom_range(0, 3) == 0) begin
					hold = $urandom_range(1, eff);
				end else begin
					hold = eff + $urandom_range(0, 4);
				end
				repeat (hold) begin
					s = pat;
					// occasional contact bounce
					if ($urandom_range(0, 15) == 0) begin
						pos = $urandom_range(0, 11);
						s[pos] = ~s[pos];
					end
					drive_scan(s);
					sent++;
				end
			end else begin
				repeat ($urandom_range(1, 4)) begin
					drive_scan(key_rows_t'($urandom));
					sent++;
				end
			end
		end
		drain();
	endtask

	// Receiver: stall pattern changes mode every so often; long hold-off on request
	initial begin
		int mode;
		int mode_left;
		int tick;
		mode = 0;
		mode_left = 0;
		tick = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				chord.ready <= 1'b0;
				repeat (SQUEEZE_CYCLES) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(64, 256);
				end
				mode_left--;
				tick++;
				case (mode)
					0: chord.ready <= 1'b1;
					1: chord.ready <= ($urandom_range(0, 3) != 0);
					2: chord.ready <= (tick % 3 == 0);
					default: chord.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Result monitor
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && chord.valid && chord.ready) begin
				sb.check_chord(chord.chord_root, chord.chord_type);
			end
		end
	end

	// Watchdog on cycles with no item moving
	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (scan.valid && scan.ready) || (chord.valid && chord.ready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
		$display("FAIL key_matrix_debounce_chord_detect_core");
		$finish;
	end

	// Main stimulus
	initial begin
		logic [THR_W-1:0] thr_list[8];
		sb = new();
		hold_off_req = 1'b0;
		burst_left = 0;
		settings_used = 1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		scan.valid = 1'b0;
		scan.major_row_keys = '0;
		scan.minor_row_keys = '0;
		scan.seventh_row_keys = '0;
		chord.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset threshold: bounce that falls short, then a press that holds
		drive_scan('{4'hF, 4'hF, 4'hF});
		drive_scan('{4'hF, 4'hF, 4'hF});
		drive_scan('{4'h0, 4'h0, 4'h0});
		drive_scan('{4'hF, 4'hF, 4'hF});
		drive_scan('{4'hF, 4'hF, 4'hF});
		drive_scan('{4'hF, 4'hF, 4'hF});
		drain();

		// Threshold one: every chord type in column 0, then priority and extremes
		write_threshold(4'd1);
		drive_scan('{4'h1, 4'h0, 4'h0});
		drive_scan('{4'h0, 4'h1, 4'h0});
		drive_scan('{4'h1, 4'h0, 4'h1});
		drive_scan('{4'h0, 4'h1, 4'h1});
		drive_scan('{4'h1, 4'h1, 4'h0});
		drive_scan('{4'h1, 4'h1, 4'h1});
		drive_scan('{4'h0, 4'h0, 4'h1}); // seventh alone: no chord, root held
		drive_scan('{4'h0, 4'h0, 4'h0});
		drive_scan('{4'h8, 4'h8, 4'h0});
		drive_scan('{4'h6, 4'h4, 4'h0}); // columns 1 and 2: lower one wins
		drive_scan('{4'hF, 4'h0, 4'h0});
		drive_scan('{4'h0, 4'hF, 4'h0});
		drive_scan('{4'h0, 4'h0, 4'hF});
		drive_scan('{4'hF, 4'hF, 4'hF});
		drive_scan('{4'h0, 4'h0, 4'h0});
		drain();

		// Random phases over several thresholds, zero and both ends included
		thr_list = '{4'd1, 4'd15, 4'd0, 4'd2, 4'd5, 4'd3, 4'd9, 4'd0};
		thr_list[7] = THR_W'($urandom_range(1, 14));
		for (int p = 0; p < 8; p++) begin
			run_phase(thr_list[p], 240, p == 2);
		end

		repeat (10) @(posedge clk);
		if (sb.expected_chords.size() != 0) begin
			$error("%0d chord items never arrived", sb.expected_chords.size());
			sb.errors++;
		end
		$display("Ran %0d scans under %0d threshold settings, including one long output stall.",
			sb.scans, settings_used);
		$display("Chord items by type none..aug: %0d %0d %0d %0d %0d %0d %0d",
			sb.seen[0], sb.seen[1], sb.seen[2], sb.seen[3], sb.seen[4], sb.seen[5], sb.seen[6]);
		if (sb.errors == 0) begin
			$display("PASS key_matrix_debounce_chord_detect_core");
		end else begin
			$display("FAIL key_matrix_debounce_chord_detect_core");
		end
		$finish;
	end

endmodule
